// ===== rtl/strided_copy_burst_generator_core_macros.svh =====
// ---------------------------------------------------------------------------
// strided copy burst generator assertion macros
// concurrent assertion wrappers, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef STRIDED_COPY_BURST_GENERATOR_CORE_MACROS_SVH
`define STRIDED_COPY_BURST_GENERATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define SCBG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scbg assertion failed");
// antecedent implies consequent in the next cycle
`define SCBG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scbg assertion failed");
`else
`define SCBG_ASSERT_IMPL(label, ante, cons)
`define SCBG_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/scbg_pkg.sv =====
// ---------------------------------------------------------------------------
// scbg_pkg
// shared widths, codes and the configuration register type
// ---------------------------------------------------------------------------
`default_nettype none

package scbg_pkg;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 16;
    localparam int EB_W    = 7;
    localparam int COUNT_W = 38;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 32;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;

    // command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_NEXT  = 1'b1;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_OUTER_SIZE       = 3'd0;
    localparam logic [INDEX_W-1:0] REG_INNER_SIZE       = 3'd1;
    localparam logic [INDEX_W-1:0] REG_SRC_OUTER_STRIDE = 3'd2;
    localparam logic [INDEX_W-1:0] REG_SRC_INNER_STRIDE = 3'd3;
    localparam logic [INDEX_W-1:0] REG_DST_OUTER_STRIDE = 3'd4;
    localparam logic [INDEX_W-1:0] REG_DST_INNER_STRIDE = 3'd5;
    localparam logic [INDEX_W-1:0] REG_ELEMENT_BYTES    = 3'd6;

    typedef struct packed {
        logic        [SIZE_W-1:0] outer_size;
        logic        [SIZE_W-1:0] inner_size;
        logic signed [ADDR_W-1:0] src_outer_stride;
        logic signed [ADDR_W-1:0] src_inner_stride;
        logic signed [ADDR_W-1:0] dst_outer_stride;
        logic signed [ADDR_W-1:0] dst_inner_stride;
        logic        [EB_W-1:0]   element_bytes;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/scbg_if.sv =====
// ---------------------------------------------------------------------------
// scbg channel interfaces
// request, burst and configuration write channels with valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface scbg_req_if;
    import scbg_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADDR_W-1:0] src_base;
    logic [ADDR_W-1:0] dst_base;
    logic              operation;
    modport source (output valid, cmd, src_base, dst_base, operation, input ready);
    modport sink   (input valid, cmd, src_base, dst_base, operation, output ready);
endinterface

interface scbg_burst_if;
    import scbg_pkg::*;
    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  src_address;
    logic [ADDR_W-1:0]  dst_address;
    logic [COUNT_W-1:0] byte_count;
    logic               job_operation;
    logic               last;
    modport source (output valid, src_address, dst_address, byte_count, job_operation, last,
                    input ready);
    modport sink   (input valid, src_address, dst_address, byte_count, job_operation, last,
                    output ready);
endinterface

interface scbg_cfg_if;
    import scbg_pkg::*;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic [DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/strided_copy_burst_generator_core.sv =====
// ---------------------------------------------------------------------------
// strided_copy_burst_generator_core
// two-dimensional strided copy/compare burst generator: a start beat plans
// the job on a shared multiplier, each next beat of a live job yields one burst
// ---------------------------------------------------------------------------
//
//  channel  dir  beat payload
//  -------  ---  ---------------------------------------------------------
//  req      in   cmd, src_base, dst_base, operation
//  burst    out  src_address, dst_address, byte_count, job_operation, last
//  cfg      in   index, data (register write, always ready)
//
//  a start beat is accepted in idle, then runs six multiplier passes and a
//  finalize state; req.ready is low in all of the planning states
//  next beats issue bursts back to back from the walker unless burst.ready is low
//  reset leaves no job active; a next beat then gives no burst
//  the burst register holds its beat while burst.ready is low, and a new
//  req beat is taken only when that register is free or being emptied
//
`default_nettype none
`include "strided_copy_burst_generator_core_macros.svh"

module strided_copy_burst_generator_core (
    input  wire        clk,
    input  wire        rst_n,
    scbg_req_if.sink   req,
    scbg_burst_if.source burst,
    scbg_cfg_if.sink   cfg
);
    import scbg_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M0   = 3'd1;  // src inner stride * inner size
    localparam logic [2:0] ST_M1   = 3'd2;  // dst inner stride * inner size
    localparam logic [2:0] ST_M2   = 3'd3;  // outer size * inner size
    localparam logic [2:0] ST_M3   = 3'd4;  // block * element bytes
    localparam logic [2:0] ST_M4   = 3'd5;  // (block - 1) * src inner stride
    localparam logic [2:0] ST_M5   = 3'd6;  // (block - 1) * dst inner stride
    localparam logic [2:0] ST_M6   = 3'd7;  // finalize

    // contiguity level codes
    localparam logic [1:0] DIM_OUTER = 2'd0;
    localparam logic [1:0] DIM_INNER = 2'd1;
    localparam logic [1:0] DIM_NONE  = 2'd2;

    cfg_t regs;

    scbg_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;

    scbg_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // control state
    logic [2:0]        state_reg, state_next;
    logic              job_active_reg, job_active_next;
    logic [ADDR_W-1:0] bursts_left_reg, bursts_left_next;
    logic              out_valid_reg, out_valid_next;

    // job payload
    logic               merged_reg, merged_next;
    logic [1:0]         merge_level_reg, merge_level_next;
    logic [SIZE_W-1:0]  inner_index_reg, inner_index_next;
    logic [ADDR_W-1:0]  src_row_reg, src_row_next;
    logic [ADDR_W-1:0]  src_cur_reg, src_cur_next;
    logic [ADDR_W-1:0]  dst_row_reg, dst_row_next;
    logic [ADDR_W-1:0]  dst_cur_reg, dst_cur_next;
    logic [COUNT_W-1:0] burst_length_reg, burst_length_next;
    logic               operation_reg, operation_next;

    // planning scratch
    logic              src_outer_ok_reg, src_outer_ok_next;
    logic              dst_outer_ok_reg, dst_outer_ok_next;
    logic [ADDR_W-1:0] total_reg, total_next;
    logic [ADDR_W-1:0] blk_reg, blk_next;

    // burst output register
    logic [ADDR_W-1:0]  out_src_reg, out_src_next;
    logic [ADDR_W-1:0]  out_dst_reg, out_dst_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_op_reg, out_op_next;
    logic               out_last_reg, out_last_next;

    logic in_acc;
    logic load_result;
    logic last_now;

    // contiguity decode
    logic [MUL_W-1:0] src_inner_abs;
    logic [MUL_W-1:0] dst_inner_abs;
    logic             src_inner_ok;
    logic             dst_inner_ok;
    logic [1:0]       src_level;
    logic [1:0]       dst_level;
    logic [1:0]       level_now;
    logic             merged_now;
    logic [ADDR_W-1:0] blk_now;
    logic              size_zero;
    logic [ADDR_W-1:0] dst_start;
    logic [SIZE_W-1:0] inner_inc;
    logic [ADDR_W-1:0] src_row_step;
    logic [ADDR_W-1:0] dst_row_step;

    assign req.ready = (state_reg == ST_IDLE) && (!out_valid_reg || burst.ready);
    assign in_acc    = req.valid && req.ready;

    assign burst.valid         = out_valid_reg;
    assign burst.src_address   = out_src_reg;
    assign burst.dst_address   = out_dst_reg;
    assign burst.byte_count    = out_count_reg;
    assign burst.job_operation = out_op_reg;
    assign burst.last          = out_last_reg;

    // a side is contiguous from the inner dimension when |inner stride| is
    // one element, and from the outer one when a row also packs exactly
    assign src_inner_abs = regs.src_inner_stride[ADDR_W-1]
                         ? (MUL_W'(0) - {regs.src_inner_stride[ADDR_W-1], regs.src_inner_stride})
                         : {1'b0, regs.src_inner_stride};
    assign dst_inner_abs = regs.dst_inner_stride[ADDR_W-1]
                         ? (MUL_W'(0) - {regs.dst_inner_stride[ADDR_W-1], regs.dst_inner_stride})
                         : {1'b0, regs.dst_inner_stride};
    assign src_inner_ok  = (src_inner_abs == MUL_W'(regs.element_bytes));
    assign dst_inner_ok  = (dst_inner_abs == MUL_W'(regs.element_bytes));

    assign src_level = !src_inner_ok ? DIM_NONE : (src_outer_ok_reg ? DIM_OUTER : DIM_INNER);
    assign dst_level = !dst_inner_ok ? DIM_NONE : (dst_outer_ok_reg ? DIM_OUTER : DIM_INNER);
    assign level_now = (src_level > dst_level) ? src_level : dst_level;

    // merging needs matching stride signs at the chosen level
    always_comb
    begin
        case (level_now)
            DIM_OUTER: merged_now = (regs.src_outer_stride[ADDR_W-1]
                                     == regs.dst_outer_stride[ADDR_W-1]);
            DIM_INNER: merged_now = (regs.src_inner_stride[ADDR_W-1]
                                     == regs.dst_inner_stride[ADDR_W-1]);
            default:   merged_now = 1'b0;
        endcase
    end

    // block elements: whole job from outer level, one row from inner level
    assign blk_now   = (level_now == DIM_OUTER) ? prod[ADDR_W-1:0]
                                                : ADDR_W'(regs.inner_size);
    assign size_zero = (regs.outer_size == '0) || (regs.inner_size == '0);
    assign dst_start = (merged_reg && regs.dst_inner_stride[ADDR_W-1])
                     ? (dst_row_reg + prod[ADDR_W-1:0]) : dst_row_reg;

    // walker arithmetic
    assign inner_inc    = inner_index_reg + SIZE_W'(1);
    assign src_row_step = src_row_reg + regs.src_outer_stride;
    assign dst_row_step = dst_row_reg + regs.dst_outer_stride;

    assign load_result = in_acc && (req.cmd == CMD_NEXT) && job_active_reg
                       && (bursts_left_reg != '0);
    assign last_now    = (bursts_left_reg == ADDR_W'(1));

    always_comb
    begin
        state_next        = state_reg;
        job_active_next   = job_active_reg;
        bursts_left_next  = bursts_left_reg;
        out_valid_next    = burst.ready ? 1'b0 : out_valid_reg;
        merged_next       = merged_reg;
        merge_level_next  = merge_level_reg;
        inner_index_next  = inner_index_reg;
        src_row_next      = src_row_reg;
        src_cur_next      = src_cur_reg;
        dst_row_next      = dst_row_reg;
        dst_cur_next      = dst_cur_reg;
        burst_length_next = burst_length_reg;
        operation_next    = operation_reg;
        src_outer_ok_next = src_outer_ok_reg;
        dst_outer_ok_next = dst_outer_ok_reg;
        total_next        = total_reg;
        blk_next          = blk_reg;
        out_src_next      = out_src_reg;
        out_dst_next      = out_dst_reg;
        out_count_next    = out_count_reg;
        out_op_next       = out_op_reg;
        out_last_next     = out_last_reg;
        mul_a             = '0;
        mul_b             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (req.cmd == CMD_START)
                    begin
                        // drop any running job and plan the new one
                        state_next      = ST_M0;
                        job_active_next = 1'b0;
                        operation_next  = req.operation;
                        src_row_next    = req.src_base;
                        dst_row_next    = req.dst_base;
                    end
                    else if (load_result)
                    begin
                        out_valid_next   = 1'b1;
                        out_src_next     = src_cur_reg;
                        out_dst_next     = dst_cur_reg;
                        out_count_next   = burst_length_reg;
                        out_op_next      = operation_reg;
                        out_last_next    = last_now;
                        bursts_left_next = bursts_left_reg - ADDR_W'(1);
                        if (last_now)
                        begin
                            job_active_next = 1'b0;
                        end
                        else if (merged_reg)
                        begin
                            // merged rows step by the outer stride
                            if (merge_level_reg == DIM_INNER)
                            begin
                                src_row_next = src_row_step;
                                src_cur_next = src_row_step;
                                dst_row_next = dst_row_step;
                                dst_cur_next = dst_row_step;
                            end
                        end
                        else if (inner_inc >= regs.inner_size)
                        begin
                            // end of row in element mode
                            inner_index_next = '0;
                            src_row_next     = src_row_step;
                            src_cur_next     = src_row_step;
                            dst_row_next     = dst_row_step;
                            dst_cur_next     = dst_row_step;
                        end
                        else
                        begin
                            inner_index_next = inner_inc;
                            src_cur_next     = src_cur_reg + regs.src_inner_stride;
                            dst_cur_next     = dst_cur_reg + regs.dst_inner_stride;
                        end
                    end
                    else
                    begin
                        job_active_next = 1'b0;
                    end
                end
            end
            ST_M0:
            begin
                mul_a      = {regs.src_inner_stride[ADDR_W-1], regs.src_inner_stride};
                mul_b      = MUL_W'(regs.inner_size);
                state_next = ST_M1;
            end
            ST_M1:
            begin
                src_outer_ok_next = (prod == PROD_W'(regs.src_outer_stride));
                mul_a             = {regs.dst_inner_stride[ADDR_W-1], regs.dst_inner_stride};
                mul_b             = MUL_W'(regs.inner_size);
                state_next        = ST_M2;
            end
            ST_M2:
            begin
                dst_outer_ok_next = (prod == PROD_W'(regs.dst_outer_stride));
                mul_a             = MUL_W'(regs.outer_size);
                mul_b             = MUL_W'(regs.inner_size);
                state_next        = ST_M3;
            end
            ST_M3:
            begin
                total_next       = prod[ADDR_W-1:0];
                merge_level_next = level_now;
                merged_next      = merged_now;
                blk_next         = blk_now;
                mul_a            = MUL_W'(regs.element_bytes);
                mul_b            = MUL_W'(blk_now);
                state_next       = ST_M4;
            end
            ST_M4:
            begin
                burst_length_next = merged_reg ? prod[COUNT_W-1:0]
                                               : COUNT_W'(regs.element_bytes);
                mul_a             = {regs.src_inner_stride[ADDR_W-1], regs.src_inner_stride};
                mul_b             = MUL_W'(blk_reg - ADDR_W'(1));
                state_next        = ST_M5;
            end
            ST_M5:
            begin
                // negative inner stride: merged block starts at its low end
                if (merged_reg && regs.src_inner_stride[ADDR_W-1])
                begin
                    src_row_next = src_row_reg + prod[ADDR_W-1:0];
                end
                mul_a      = {regs.dst_inner_stride[ADDR_W-1], regs.dst_inner_stride};
                mul_b      = MUL_W'(blk_reg - ADDR_W'(1));
                state_next = ST_M6;
            end
            ST_M6:
            begin
                dst_row_next     = dst_start;
                dst_cur_next     = dst_start;
                src_cur_next     = src_row_reg;
                inner_index_next = '0;
                if (size_zero)
                begin
                    bursts_left_next = '0;
                    burst_length_next = '0;
                end
                else if (merged_reg)
                begin
                    bursts_left_next = (merge_level_reg == DIM_OUTER)
                                     ? ADDR_W'(1) : ADDR_W'(regs.outer_size);
                end
                else
                begin
                    bursts_left_next = total_reg;
                end
                job_active_next = !size_zero;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            job_active_reg  <= 1'b0;
            bursts_left_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            job_active_reg  <= job_active_next;
            bursts_left_reg <= bursts_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        merged_reg       <= merged_next;
        merge_level_reg  <= merge_level_next;
        inner_index_reg  <= inner_index_next;
        src_row_reg      <= src_row_next;
        src_cur_reg      <= src_cur_next;
        dst_row_reg      <= dst_row_next;
        dst_cur_reg      <= dst_cur_next;
        burst_length_reg <= burst_length_next;
        operation_reg    <= operation_next;
        src_outer_ok_reg <= src_outer_ok_next;
        dst_outer_ok_reg <= dst_outer_ok_next;
        total_reg        <= total_next;
        blk_reg          <= blk_next;
        out_src_reg      <= out_src_next;
        out_dst_reg      <= out_dst_next;
        out_count_reg    <= out_count_next;
        out_op_reg       <= out_op_next;
        out_last_reg     <= out_last_next;
    end

    // a start beat always enters the planning sequence
    `SCBG_ASSERT_NEXT(a_start_plans, in_acc && (req.cmd == CMD_START), state_reg == ST_M0)
    // an active job always has bursts to give
    `SCBG_ASSERT_IMPL(a_active_has_bursts, job_active_reg, bursts_left_reg != '0)
    // the final burst closes the job
    `SCBG_ASSERT_NEXT(a_last_ends_job, load_result && last_now, !job_active_reg)
    // no req beat is taken while planning
    `SCBG_ASSERT_IMPL(a_busy_not_ready, state_reg != ST_IDLE, !req.ready)

endmodule

`default_nettype wire

// ===== rtl/scbg_cfg.sv =====
// ---------------------------------------------------------------------------
// scbg_cfg
// configuration register file, always ready for a write beat
// ---------------------------------------------------------------------------
`default_nettype none

module scbg_cfg (
    input  wire            clk,
    input  wire            rst_n,
    scbg_cfg_if.sink       cfg,
    output scbg_pkg::cfg_t regs
);
    import scbg_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_OUTER_SIZE:       regs_next.outer_size       = cfg.data[SIZE_W-1:0];
                REG_INNER_SIZE:       regs_next.inner_size       = cfg.data[SIZE_W-1:0];
                REG_SRC_OUTER_STRIDE: regs_next.src_outer_stride = cfg.data;
                REG_SRC_INNER_STRIDE: regs_next.src_inner_stride = cfg.data;
                REG_DST_OUTER_STRIDE: regs_next.dst_outer_stride = cfg.data;
                REG_DST_INNER_STRIDE: regs_next.dst_inner_stride = cfg.data;
                REG_ELEMENT_BYTES:    regs_next.element_bytes    = cfg.data[EB_W-1:0];
                default:              regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.outer_size       <= SIZE_W'(1);
            regs_reg.inner_size       <= SIZE_W'(1);
            regs_reg.src_outer_stride <= '0;
            regs_reg.src_inner_stride <= ADDR_W'(1);
            regs_reg.dst_outer_stride <= '0;
            regs_reg.dst_inner_stride <= ADDR_W'(1);
            regs_reg.element_bytes    <= EB_W'(1);
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scbg_mul.sv =====
// ---------------------------------------------------------------------------
// scbg_mul
// shared signed multiplier with a registered product
// ---------------------------------------------------------------------------
`default_nettype none

module scbg_mul (
    input  wire                                  clk,
    input  wire  signed [scbg_pkg::MUL_W-1:0]    a,
    input  wire  signed [scbg_pkg::MUL_W-1:0]    b,
    output logic signed [scbg_pkg::PROD_W-1:0]   prod
);
    import scbg_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

`default_nettype wire

// ===== tb/scbg_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// scbg_tb_pkg
// burst walker check: follows the job state of the burst generator and holds
// the bursts that are still due, compared against what the block emits
// ---------------------------------------------------------------------------
package scbg_tb_pkg;
    import scbg_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]  src_address;
        logic [ADDR_W-1:0]  dst_address;
        logic [COUNT_W-1:0] byte_count;
        logic               job_operation;
        logic               last;
    } burst_beat_t;

    class burst_walker_check;
        // register copy
        bit [SIZE_W-1:0]  outer_size;
        bit [SIZE_W-1:0]  inner_size;
        int               src_outer_stride;
        int               src_inner_stride;
        int               dst_outer_stride;
        int               dst_inner_stride;
        bit [EB_W-1:0]    element_bytes;
        // job state
        bit               job_active;
        bit               merged_mode;
        bit               stored_op;
        bit [1:0]         merge_level;
        bit [SIZE_W-1:0]  outer_index;
        bit [SIZE_W-1:0]  inner_index;
        bit [ADDR_W-1:0]  src_row;
        bit [ADDR_W-1:0]  src_cur;
        bit [ADDR_W-1:0]  dst_row;
        bit [ADDR_W-1:0]  dst_cur;
        bit [31:0]        bursts_left;
        bit [COUNT_W-1:0] burst_length;
        burst_beat_t      bursts_due[$];
        int               mismatches;

        function new();
            outer_size       = 1;
            inner_size       = 1;
            src_outer_stride = 0;
            src_inner_stride = 1;
            dst_outer_stride = 0;
            dst_inner_stride = 1;
            element_bytes    = 1;
            job_active       = 0;
            merged_mode      = 0;
            stored_op        = 0;
            merge_level      = 0;
            outer_index      = 0;
            inner_index      = 0;
            src_row          = 0;
            src_cur          = 0;
            dst_row          = 0;
            dst_cur          = 0;
            bursts_left      = 0;
            burst_length     = 0;
            mismatches       = 0;
        endfunction

        function void write_reg(bit [INDEX_W-1:0] index, bit [DATA_W-1:0] data);
            case (index)
                REG_OUTER_SIZE:       outer_size       = data[SIZE_W-1:0];
                REG_INNER_SIZE:       inner_size       = data[SIZE_W-1:0];
                REG_SRC_OUTER_STRIDE: src_outer_stride = int'(data);
                REG_SRC_INNER_STRIDE: src_inner_stride = int'(data);
                REG_DST_OUTER_STRIDE: dst_outer_stride = int'(data);
                REG_DST_INNER_STRIDE: dst_inner_stride = int'(data);
                REG_ELEMENT_BYTES:    element_bytes    = data[EB_W-1:0];
                default: ;
            endcase
        endfunction

        // lowest dimension from which one side is contiguous, 2 for none
        function int contiguous_from(int outer_st, int inner_st);
            longint mag;
            longint span;
            mag = (inner_st < 0) ? -longint'(inner_st) : longint'(inner_st);
            if (mag != longint'(element_bytes))
                return 2;
            span = longint'(inner_st) * longint'(inner_size);
            return (longint'(outer_st) == span) ? 0 : 1;
        endfunction

        function void plan_job(bit [ADDR_W-1:0] sbase, bit [ADDR_W-1:0] dbase, bit op);
            int              sc;
            int              dc;
            int              lvl;
            bit              src_neg;
            bit              dst_neg;
            longint unsigned blk;
            longint unsigned cnt;
            sc  = contiguous_from(src_outer_stride, src_inner_stride);
            dc  = contiguous_from(dst_outer_stride, dst_inner_stride);
            lvl = (sc > dc) ? sc : dc;
            src_neg = (lvl == 1) ? (src_inner_stride < 0) : (src_outer_stride < 0);
            dst_neg = (lvl == 1) ? (dst_inner_stride < 0) : (dst_outer_stride < 0);
            stored_op   = op;
            outer_index = 0;
            inner_index = 0;
            merged_mode = (lvl < 2) && (src_neg == dst_neg);
            merge_level = 2'(lvl);
            if (outer_size == 0 || inner_size == 0) begin
                job_active   = 0;
                bursts_left  = 0;
                burst_length = 0;
                return;
            end
            if (merged_mode) begin
                blk = inner_size;
                cnt = outer_size;
                if (lvl == 0) begin
                    blk = blk * outer_size;
                    cnt = 1;
                end
                burst_length = COUNT_W'(blk * element_bytes);
                // negative inner stride: the block starts at its lowest address
                if (src_inner_stride < 0)
                    sbase = sbase + ADDR_W'((blk - 1) * longint'(src_inner_stride));
                if (dst_inner_stride < 0)
                    dbase = dbase + ADDR_W'((blk - 1) * longint'(dst_inner_stride));
            end
            else begin
                cnt = longint'(outer_size) * longint'(inner_size);
                burst_length = COUNT_W'(element_bytes);
            end
            src_row     = sbase;
            src_cur     = sbase;
            dst_row     = dbase;
            dst_cur     = dbase;
            bursts_left = 32'(cnt);
            job_active  = (bursts_left != 0);
        endfunction

        function void next_row();
            outer_index = outer_index + 1'b1;
            src_row     = src_row + src_outer_stride;
            dst_row     = dst_row + dst_outer_stride;
            src_cur     = src_row;
            dst_cur     = dst_row;
        endfunction

        function void step_walk();
            if (merged_mode) begin
                if (merge_level == 2'd1)
                    next_row();
                return;
            end
            inner_index = inner_index + 1'b1;
            src_cur     = src_cur + src_inner_stride;
            dst_cur     = dst_cur + dst_inner_stride;
            if (inner_index >= inner_size) begin
                inner_index = 0;
                next_row();
            end
        endfunction

        function void issue_burst();
            burst_beat_t beat;
            if (!job_active || bursts_left == 0) begin
                job_active = 0;
                return;
            end
            beat.src_address   = src_cur;
            beat.dst_address   = dst_cur;
            beat.byte_count    = burst_length;
            beat.job_operation = stored_op;
            bursts_left        = bursts_left - 1;
            beat.last          = (bursts_left == 0);
            bursts_due.push_back(beat);
            if (bursts_left == 0)
                job_active = 0;
            else
                step_walk();
        endfunction

        // accepted request beat
        function void note_request(bit cmd, bit [ADDR_W-1:0] sbase, bit [ADDR_W-1:0] dbase,
                                   bit op);
            if (cmd == CMD_START)
                plan_job(sbase, dbase, op);
            else
                issue_burst();
        endfunction

        // accepted burst beat
        function void check_burst(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst,
                                  logic [COUNT_W-1:0] bytes, logic op, logic fin);
            burst_beat_t want;
            if (bursts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("burst with none due: src %h dst %h bytes %h op %b last %b",
                             src, dst, bytes, op, fin);
                return;
            end
            want = bursts_due.pop_front();
            if (src !== want.src_address || dst !== want.dst_address ||
                bytes !== want.byte_count || op !== want.job_operation ||
                fin !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("burst mismatch: expected src %h dst %h bytes %h op %b last %b, %s",
                             want.src_address, want.dst_address, want.byte_count,
                             want.job_operation, want.last,
                             $sformatf("got src %h dst %h bytes %h op %b last %b",
                                       src, dst, bytes, op, fin));
            end
        endfunction

        function int pending();
            return bursts_due.size();
        endfunction

        function longint unsigned bursts_to_go();
            return job_active ? longint'(bursts_left) : 0;
        endfunction
    endclass

endpackage

// ===== tb/tb_strided_copy_burst_generator_core.sv =====
// ---------------------------------------------------------------------------
// tb_strided_copy_burst_generator_core
// drives start and next beats with random gaps and back-pressure, programs
// the stride and size registers between phases, and checks every burst
// against a walker that tracks the job state beat by beat
// ---------------------------------------------------------------------------
module tb_strided_copy_burst_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import scbg_pkg::*;
    import scbg_tb_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 24;       // let start planning finish, keep margin
    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_BUDGET  = 1350;
    localparam int MAX_WALK     = 40;       // longer jobs are cut short by a new start

    localparam logic OP_COPY    = 1'b0;
    localparam logic OP_COMPARE = 1'b1;
    localparam logic [INDEX_W-1:0] REG_UNUSED = 3'd7;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   items_sent;

    burst_walker_check walker;

    scbg_req_if   req_ch();
    scbg_burst_if burst_ch();
    scbg_cfg_if   cfg_ch();

    strided_copy_burst_generator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .burst (burst_ch),
        .cfg   (cfg_ch)
    );

    // 20 ns clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hang guard
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // every burst beat taken is checked against the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && burst_ch.valid && burst_ch.ready)
            walker.check_burst(burst_ch.src_address, burst_ch.dst_address,
                               burst_ch.byte_count, burst_ch.job_operation, burst_ch.last);
    end

    // burst sink: random stall before each beat, none when idling is off
    initial
    begin
        int gap;
        burst_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            gap = idle_on ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                burst_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_ch.ready <= 1'b1;
            do @(posedge clk); while (!burst_ch.valid);
        end
    end

    // one request beat; valid stays high into the next beat when no gap is drawn
    task automatic send_req(input logic cmd, input logic [ADDR_W-1:0] sbase,
                            input logic [ADDR_W-1:0] dbase, input logic op);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.cmd       <= cmd;
        req_ch.src_base  <= sbase;
        req_ch.dst_base  <= dbase;
        req_ch.operation <= op;
        do @(posedge clk); while (!req_ch.ready);
        // next beats with no job are ignored by the block and not counted
        if (cmd == CMD_START || walker.bursts_to_go() != 0)
            items_sent++;
        walker.note_request(cmd, sbase, dbase, op);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        walker.write_reg(index, data);
    endtask

    task automatic load_regs(input logic [DATA_W-1:0] osz, input logic [DATA_W-1:0] isz,
                             input logic [DATA_W-1:0] s_out, input logic [DATA_W-1:0] s_in,
                             input logic [DATA_W-1:0] d_out, input logic [DATA_W-1:0] d_in,
                             input logic [DATA_W-1:0] eb);
        write_reg(REG_OUTER_SIZE, osz);
        write_reg(REG_INNER_SIZE, isz);
        write_reg(REG_SRC_OUTER_STRIDE, s_out);
        write_reg(REG_SRC_INNER_STRIDE, s_in);
        write_reg(REG_DST_OUTER_STRIDE, d_out);
        write_reg(REG_DST_INNER_STRIDE, d_in);
        write_reg(REG_ELEMENT_BYTES, eb);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait for every due burst, then let a start that gives none finish planning
    task automatic settle();
        req_ch.valid <= 1'b0;
        while (walker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // mostly small sizes, a few large ones and the odd zero
    function automatic logic [SIZE_W-1:0] pick_size(input int small_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return SIZE_W'($urandom_range(1, small_max));
        if (r < 88)
            return SIZE_W'($urandom_range(small_max + 1, 40));
        if (r < 93)
            return 16'hFFFF;
        if (r < 98)
            return SIZE_W'($urandom);
        return 16'h0000;
    endfunction

    // element bytes past 64 and zero are taken as given
    function automatic logic [EB_W-1:0] pick_element_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return EB_W'($urandom_range(1, 64));
        if (r < 93)
            return EB_W'($urandom_range(65, 127));
        return 7'd0;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // inner stride: mostly plus or minus one element so bursts merge
    function automatic logic [ADDR_W-1:0] pick_inner_stride(input logic [EB_W-1:0] eb);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 1) ? ADDR_W'(-int'(eb)) : ADDR_W'(int'(eb));
        if (r < 80)
            return ADDR_W'($urandom_range(0, 512) - 256);
        if (r < 90)
            return $urandom;
        return pick_extreme();
    endfunction

    // outer stride: mostly one full row so the whole job merges into one burst
    function automatic logic [ADDR_W-1:0] pick_outer_stride(input logic [ADDR_W-1:0] s_in,
                                                            input logic [SIZE_W-1:0] isz);
        longint row_span;
        int     r;
        row_span = longint'($signed(s_in)) * longint'(isz);
        r = $urandom_range(0, 99);
        if (r < 55)
            return ADDR_W'(row_span);
        if (r < 80)
            return ADDR_W'(row_span + $urandom_range(1, 64));
        if (r < 90)
            return $urandom;
        return pick_extreme();
    endfunction

    // start a job and mostly walk it to the last burst; sometimes one more next
    // beat past the end, sometimes a cut-off by the following start
    task automatic run_job();
        longint unsigned due;
        int              nexts;
        int              r;
        send_req(CMD_START, $urandom, $urandom, 1'($urandom));
        due = walker.bursts_to_go();
        r = $urandom_range(0, 99);
        if (due > MAX_WALK)
            nexts = $urandom_range(1, 12);
        else if (r < 75)
            nexts = int'(due);
        else if (r < 88)
            nexts = int'(due) + 1;
        else
            nexts = (due == 0) ? 1 : $urandom_range(0, int'(due) - 1);
        repeat (nexts) send_req(CMD_NEXT, $urandom, $urandom, 1'($urandom));
    endtask

    task automatic random_phase();
        logic [SIZE_W-1:0] osz;
        logic [SIZE_W-1:0] isz;
        logic [EB_W-1:0]   eb;
        logic [ADDR_W-1:0] s_in;
        logic [ADDR_W-1:0] d_in;
        osz  = pick_size(5);
        isz  = pick_size(6);
        eb   = pick_element_bytes();
        s_in = pick_inner_stride(eb);
        d_in = pick_inner_stride(eb);
        idle_on = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 15) == 0)
            write_reg(REG_UNUSED, $urandom);
        // upper data bits above the register width are junk on purpose
        load_regs({16'($urandom), osz}, {16'($urandom), isz},
                  pick_outer_stride(s_in, isz), s_in,
                  pick_outer_stride(d_in, isz), d_in,
                  {25'($urandom), eb});
        // a cut-off job keeps walking with the new strides and sizes
        if (walker.bursts_to_go() != 0 && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) send_req(CMD_NEXT, $urandom, $urandom, 1'($urandom));
        repeat ($urandom_range(3, 7)) run_job();
        settle();
    endtask

    task automatic run_directed();
        // next with no job after reset
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        // reset registers: one merged burst of one byte, then nothing
        send_req(CMD_START, 32'h0, 32'h0, OP_COPY);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        send_req(CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_COMPARE);
        send_req(CMD_NEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_COMPARE);
        settle();

        // both sides fully contiguous going down: one burst from the low end
        load_regs(2, 3, -12, -4, -12, -4, 4);
        send_req(CMD_START, 32'h10, 32'h8, OP_COMPARE);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        settle();

        // inner strides of opposite sign: per element, start during a job
        load_regs(2, 2, 128, 64, 1000, -64, 64);
        send_req(CMD_START, 32'd1000, 32'd2000, OP_COPY);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        send_req(CMD_START, 32'hFFFF_FFC0, 32'h40, OP_COMPARE);
        repeat (4) send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        settle();

        // no contiguous dimension, extreme strides, zero element bytes,
        // and a write past the register list
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        load_regs(1, 1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_req(CMD_START, 32'h1234_5678, 32'h8765_4321, OP_COPY);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        settle();

        // zero outer size: job is dead at once
        load_regs(0, 5, 0, 1, 0, 1, 127);
        send_req(CMD_START, 32'h100, 32'h200, OP_COMPARE);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        settle();

        // largest sizes, 127-byte elements going down: byte count wraps
        load_regs(65535, 65535, -8322945, -127, -8322945, -127, 127);
        send_req(CMD_START, 32'h0, 32'h0, OP_COPY);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        settle();

        // largest sizes at 64 bytes: the longest legal burst
        load_regs(65535, 65535, 4194240, 64, 4194240, 64, 64);
        send_req(CMD_START, 32'hAAAA_AAAA, 32'h5555_5555, OP_COMPARE);
        send_req(CMD_NEXT, 32'h0, 32'h0, OP_COPY);
        settle();
    endtask

    initial
    begin
        walker     = new();
        idle_on    = 1'b1;
        items_sent = 0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.cmd       <= CMD_START;
        req_ch.src_base  <= '0;
        req_ch.dst_base  <= '0;
        req_ch.operation <= OP_COPY;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= REG_OUTER_SIZE;
        cfg_ch.data      <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        while (items_sent < ITEM_BUDGET)
            random_phase();
        settle();

        if (walker.mismatches == 0 && walker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
